/* hw/rtl/ring_queue_with_max_query_assert.svh */
// Assertion macros used by the ring queue datapath.
`ifndef RING_QUEUE_WITH_MAX_QUERY_ASSERT_SVH
`define RING_QUEUE_WITH_MAX_QUERY_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define RQMQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rqmq assertion failed");

// Next-cycle implication, disabled while reset is active.
`define RQMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rqmq assertion failed");

`endif

/* hw/rtl/rqmq_pkg.sv */
// Shared types and constants for the ring queue with max query.
package rqmq_pkg;

    // Default number of storage entries.
    localparam int DEPTH_DEFAULT = 32;

    // Payload and register widths.
    localparam int DATA_W     = 32;
    localparam int CAP_W      = 6;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register map: word index of each register.
    localparam logic REG_IDX_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    // Operation requested by an input request.
    typedef enum logic [1:0] {
        KIND_ENQ   = 2'd0,
        KIND_DEQ   = 2'd1,
        KIND_MAX   = 2'd2,
        KIND_DRAIN = 2'd3
    } kind_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Memory read address select.
    typedef enum logic [1:0] {
        RD_HEAD,
        RD_HEAD_INC,
        RD_SCAN
    } rd_sel_t;

    // Source of a result loaded into the output register.
    typedef enum logic [2:0] {
        OUT_NONE,
        OUT_FULL,
        OUT_EMPTY,
        OUT_CACHED,
        OUT_RDATA
    } out_sel_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_OP,
        S_DEQ,
        S_SCAN,
        S_DRAIN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     op_load;
        logic     enq_write;
        logic     cache_clear;
        logic     cache_set;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     scan_start;
        logic     scan_run;
        out_sel_t out_sel;
        logic     out_last;
        logic     head_adv;
        logic     drain_clear;
    } rqmq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        kind_t kind;
        logic  full;
        logic  empty;
        logic  cache_valid;
        logic  out_free;
        logic  scan_done;
        logic  last_entry;
    } rqmq_stat_t;

endpackage

/* hw/rtl/rqmq_ctrl.sv */
// Controller state machine for the ring queue with max query.
module rqmq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rqmq_pkg::rqmq_stat_t stat,
    output rqmq_pkg::rqmq_cmd_t  cmd
);
    import rqmq_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_OP;
                end
            end
            S_OP:
            begin
                case (stat.kind)
                    KIND_ENQ:
                    begin
                        if (!stat.full || stat.out_free)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    KIND_DEQ:
                    begin
                        if (!stat.empty)
                        begin
                            state_next = S_DEQ;
                        end
                        else if (stat.out_free)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    KIND_MAX:
                    begin
                        if (!stat.empty && !stat.cache_valid)
                        begin
                            state_next = S_SCAN;
                        end
                        else if (stat.out_free)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    KIND_DRAIN:
                    begin
                        if (!stat.empty)
                        begin
                            state_next = S_DRAIN;
                        end
                        else if (stat.out_free)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_DEQ:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                // Back to the op state, which then returns the cached maximum.
                if (stat.scan_done)
                begin
                    state_next = S_OP;
                end
            end
            S_DRAIN:
            begin
                if (stat.out_free && stat.last_entry)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.op_load = in_valid;
            end
            S_OP:
            begin
                case (stat.kind)
                    KIND_ENQ:
                    begin
                        cmd.cache_clear = 1'b1;
                        if (!stat.full)
                        begin
                            cmd.enq_write = 1'b1;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.out_sel = OUT_FULL;
                        end
                    end
                    KIND_DEQ:
                    begin
                        cmd.cache_clear = 1'b1;
                        if (!stat.empty)
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_HEAD;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.out_sel = OUT_EMPTY;
                        end
                    end
                    KIND_MAX:
                    begin
                        if (stat.empty)
                        begin
                            if (stat.out_free)
                            begin
                                cmd.out_sel = OUT_EMPTY;
                            end
                        end
                        else if (stat.cache_valid)
                        begin
                            if (stat.out_free)
                            begin
                                cmd.out_sel = OUT_CACHED;
                            end
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                        end
                    end
                    KIND_DRAIN:
                    begin
                        if (!stat.empty)
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_HEAD;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.out_sel = OUT_EMPTY;
                        end
                    end
                    default:
                    begin
                        cmd = '0;
                    end
                endcase
            end
            S_DEQ:
            begin
                if (stat.out_free)
                begin
                    cmd.out_sel  = OUT_RDATA;
                    cmd.out_last = 1'b1;
                    cmd.head_adv = 1'b1;
                end
            end
            S_SCAN:
            begin
                cmd.scan_run  = 1'b1;
                cmd.cache_set = stat.scan_done;
            end
            S_DRAIN:
            begin
                if (stat.out_free)
                begin
                    cmd.out_sel  = OUT_RDATA;
                    cmd.out_last = stat.last_entry;
                    cmd.head_adv = 1'b1;
                    if (stat.last_entry)
                    begin
                        cmd.drain_clear = 1'b1;
                    end
                    else
                    begin
                        // Fetch the next entry while this one goes out.
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_HEAD_INC;
                    end
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* hw/rtl/rqmq_dp.sv */
// Datapath of the ring queue: entry memory, pointers, max scan and result register.
`include "ring_queue_with_max_query_assert.svh"

module rqmq_dp #(
    parameter int DEPTH = rqmq_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rqmq_pkg::rqmq_cmd_t               cmd,
    output rqmq_pkg::rqmq_stat_t              stat,
    input  logic [rqmq_pkg::CAP_W-1:0]        capacity,
    input  logic [1:0]                        kind,
    input  logic signed [rqmq_pkg::DATA_W-1:0] value,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [1:0]                        status,
    output logic signed [rqmq_pkg::DATA_W-1:0] result_value,
    output logic                              last
);
    import rqmq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // Wrapping increment of a ring index.
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = idx + 1'b1;
        end
        return res;
    endfunction

    // Entry storage.
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Latched request.
    kind_t             op_kind_reg;
    logic [DATA_W-1:0] op_value_reg;

    // Ring pointers and fill count.
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Max cache and scan state.
    logic              cache_valid_reg, cache_valid_next;
    logic [DATA_W-1:0] cached_max_reg;
    logic [IDX_W-1:0]  scan_idx_reg;
    logic [CNT_W-1:0]  scan_left_reg, scan_left_next;
    logic              scan_rvalid_reg, scan_rvalid_next;
    logic              scan_first_reg;

    // Result register.
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic              out_last_reg;

    logic              out_free;
    logic              scan_issue;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  head_inc;
    logic [CMP_W-1:0]  cap_ext;
    logic [CMP_W-1:0]  cap_sat;
    logic [CMP_W-1:0]  depth_ext;

    // Status toward the controller.
    assign out_free  = !out_valid_reg || out_ready;
    assign cap_ext   = CMP_W'(capacity);
    assign depth_ext = CMP_W'(DEPTH);
    assign cap_sat   = (cap_ext > depth_ext) ? depth_ext : cap_ext;
    assign head_inc  = idx_inc(head_reg);

    assign stat.kind        = op_kind_reg;
    assign stat.full        = CMP_W'(count_reg) >= cap_sat;
    assign stat.empty       = (count_reg == '0);
    assign stat.cache_valid = cache_valid_reg;
    assign stat.out_free    = out_free;
    assign stat.scan_done   = (scan_left_reg == '0) && !scan_rvalid_reg;
    assign stat.last_entry  = (count_reg == CNT_W'(1));

    // Read port address and enable.
    assign scan_issue = cmd.scan_run && (scan_left_reg != '0);
    assign rd_en      = cmd.rd_en || scan_issue;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_HEAD:     rd_addr = head_reg;
            RD_HEAD_INC: rd_addr = head_inc;
            default:     rd_addr = scan_idx_reg;
        endcase
        if (scan_issue)
        begin
            rd_addr = scan_idx_reg;
        end
    end

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.enq_write)
        begin
            mem[tail_reg] <= op_value_reg;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Request latch.
    always_ff @(posedge clk)
    begin
        if (cmd.op_load)
        begin
            op_kind_reg  <= kind_t'(kind);
            op_value_reg <= value;
        end
    end

    // Pointer and count update.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.drain_clear)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        else if (cmd.enq_write)
        begin
            tail_next  = idx_inc(tail_reg);
            count_next = count_reg + 1'b1;
        end
        else if (cmd.head_adv)
        begin
            head_next  = head_inc;
            count_next = count_reg - 1'b1;
        end
    end

    // Cache valid flag.
    always_comb
    begin
        cache_valid_next = cache_valid_reg;
        if (cmd.cache_clear || cmd.drain_clear)
        begin
            cache_valid_next = 1'b0;
        end
        else if (cmd.cache_set)
        begin
            cache_valid_next = 1'b1;
        end
    end

    // Scan counters: one read issued per cycle, each compared once its registered read data returns.
    always_comb
    begin
        scan_left_next   = scan_left_reg;
        scan_rvalid_next = 1'b0;
        if (cmd.scan_start)
        begin
            scan_left_next = count_reg;
        end
        else if (scan_issue)
        begin
            scan_left_next   = scan_left_reg - 1'b1;
            scan_rvalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            cache_valid_reg <= 1'b0;
            scan_left_reg   <= '0;
            scan_rvalid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            count_reg       <= count_next;
            cache_valid_reg <= cache_valid_next;
            scan_left_reg   <= scan_left_next;
            scan_rvalid_reg <= scan_rvalid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Scan index and running maximum, kept in the cache register itself.
    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            scan_idx_reg   <= head_reg;
            scan_first_reg <= 1'b1;
        end
        else if (cmd.scan_run)
        begin
            if (scan_issue)
            begin
                scan_idx_reg <= idx_inc(scan_idx_reg);
            end
            if (scan_rvalid_reg)
            begin
                scan_first_reg <= 1'b0;
                if (scan_first_reg || ($signed(rdata_reg) > $signed(cached_max_reg)))
                begin
                    cached_max_reg <= rdata_reg;
                end
            end
        end
    end

    // Result register.
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.out_sel != OUT_NONE)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.out_sel)
            OUT_FULL:
            begin
                out_status_reg <= ST_FULL;
                out_value_reg  <= '0;
                out_last_reg   <= 1'b1;
            end
            OUT_EMPTY:
            begin
                out_status_reg <= ST_EMPTY;
                out_value_reg  <= '0;
                out_last_reg   <= 1'b1;
            end
            OUT_CACHED:
            begin
                out_status_reg <= ST_OK;
                out_value_reg  <= cached_max_reg;
                out_last_reg   <= 1'b1;
            end
            OUT_RDATA:
            begin
                out_status_reg <= ST_OK;
                out_value_reg  <= rdata_reg;
                out_last_reg   <= cmd.out_last;
            end
            default:
            begin
                out_status_reg <= out_status_reg;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign result_value = out_value_reg;
    assign last         = out_last_reg;

    // The fill count never exceeds the storage depth.
    `RQMQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    // An empty queue has its head and tail at the same entry.
    `RQMQ_ASSERT_NOW(a_empty_ptrs, clk, rst_n, count_reg == '0, head_reg == tail_reg)
    // A drain leaves the queue reset to its start with no cached maximum.
    `RQMQ_ASSERT_NEXT(a_drain_clear, clk, rst_n, cmd.drain_clear, (count_reg == '0) && (head_reg == '0) && !cache_valid_reg)
    // A result is loaded only when the result register can take it.
    `RQMQ_ASSERT_NOW(a_out_load, clk, rst_n, cmd.out_sel != OUT_NONE, out_free)

endmodule

/* hw/rtl/ring_queue_with_max_query.sv */
// Top level of the ring queue with max query: register port, controller and datapath.
//
// Channel   Direction  Handshake             Payload
// in        request    in_valid / in_ready   kind, value
// out       result     out_valid / out_ready status, result_value, last
// cfg       APB write  psel, penable, pwrite paddr, pwdata (capacity at 0x0)
//
// One request is taken at a time; in_ready is high only while the controller is idle.
// A max query returns the cached result when one is valid, else scans the queue first.
// During a drain, each entry uses the single memory read port once.
// Dequeue, max query and drain on an empty queue return an empty status.
// Results wait in an output register; out_ready low stalls the controller until it drains.
// Reset clears pointers, count and cache; entry storage is not cleared.
module ring_queue_with_max_query #(
    parameter int DEPTH = rqmq_pkg::DEPTH_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [1:0]                             kind,
    input  logic signed [rqmq_pkg::DATA_W-1:0]     value,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [1:0]                             status,
    output logic signed [rqmq_pkg::DATA_W-1:0]     result_value,
    output logic                                   last,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [rqmq_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [rqmq_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [rqmq_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready
);
    import rqmq_pkg::*;

    logic [CAP_W-1:0] capacity_reg;
    logic [CAP_W-1:0] capacity_next;
    logic             cap_sel;
    rqmq_cmd_t        cmd;
    rqmq_stat_t       stat;

    // Register decode on the word index.
    assign pready  = 1'b1;
    assign cap_sel = (paddr[APB_ADDR_W-1:2] == REG_IDX_CAPACITY);

    always_comb
    begin
        capacity_next = capacity_reg;
        if (psel && penable && pwrite && pready && cap_sel)
        begin
            capacity_next = pwdata[CAP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    // Read data.
    assign prdata = cap_sel ? APB_DATA_W'(capacity_reg) : '0;

    rqmq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rqmq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .capacity     (capacity_reg),
        .kind         (kind),
        .value        (value),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .status       (status),
        .result_value (result_value),
        .last         (last)
    );

endmodule
